>>> design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, types and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // heap geometry
    localparam int HEAP_BYTES   = 1024;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_BLOCKS   = 32;

    localparam int ADDR_W = $clog2(HEAP_BYTES);
    localparam int REQ_W  = ADDR_W + 1;
    localparam int SPLIT_W = 11;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    // holds request + header + min_split with margin
    localparam int ALU_W  = ((ADDR_W > SPLIT_W) ? ADDR_W : SPLIT_W) + 2;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ADDR_W-1:0]  blk_size_t;
    typedef logic [REQ_W-1:0]   req_size_t;
    typedef logic [SPLIT_W-1:0] split_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ALU_W-1:0]   alu_word_t;

    localparam alu_word_t HDR_WORD  = alu_word_t'(HEADER_BYTES);
    localparam blk_size_t INIT_SIZE =
        (HEAP_BYTES > HEADER_BYTES) ? blk_size_t'(HEAP_BYTES - HEADER_BYTES) : '0;
    localparam split_t    MIN_SPLIT_RST = split_t'(32);
    localparam cnt_t      CNT_MAX       = cnt_t'(MAX_BLOCKS);

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOFIT   = 2'd1;
    localparam logic [1:0] STATUS_BADADDR = 2'd2;

    // command beat
    typedef struct packed {
        logic      mode;
        req_size_t alloc_size;
        addr_t     free_address;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic [1:0] status;
        addr_t      granted_address;
        blk_size_t  granted_size;
    } res_t;

    // one block table entry
    typedef struct packed {
        addr_t     offset;
        blk_size_t size;
        logic      is_free;
    } entry_t;

    localparam entry_t ENTRY_INIT = '{offset: '0, size: INIT_SIZE, is_free: 1'b1};

    typedef enum logic [1:0] {
        TBL_NOP,
        TBL_WRITE,
        TBL_INSERT,
        TBL_REMOVE
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t op;
        idx_t    idx;
        entry_t  wdata;
    } tbl_ctl_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_NEED,
        ST_A_THR,
        ST_A_SCAN,
        ST_A_CHK,
        ST_A_NOFF,
        ST_A_NSIZE,
        ST_A_INS,
        ST_A_GRANT,
        ST_F_SCAN,
        ST_F_NEXT,
        ST_F_MRGN,
        ST_F_RMN,
        ST_F_WRI,
        ST_F_PREV,
        ST_F_MRGP,
        ST_F_WRP,
        ST_F_RMI
    } state_t;

endpackage

>>> design/ffba_alu.sv
// ----------------------------------------------------------------------------
// ffba_alu
// Shared add / subtract-compare unit used by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module ffba_alu
(
    input  ffba_pkg::alu_op_t   op,
    input  ffba_pkg::alu_word_t a,
    input  ffba_pkg::alu_word_t b,
    output ffba_pkg::alu_word_t sum,
    output logic                ge
);

    logic [ffba_pkg::ALU_W:0] wide;

    always_comb
    begin
        case (op)
            ffba_pkg::ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default:           wide = {1'b0, a} + {1'b0, b};
        endcase
    end

    assign sum = wide[ffba_pkg::ALU_W-1:0];
    // no borrow on a subtract: a >= b
    assign ge  = ~wide[ffba_pkg::ALU_W];

endmodule

>>> design/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// Address-ordered block table: a row of entry cells with write, insert
// (shift up) and remove (shift down), plus the live entry count.
// ----------------------------------------------------------------------------
module ffba_table
(
    input  logic               clk,
    input  logic               rst_n,
    input  ffba_pkg::tbl_ctl_t ctl,
    input  ffba_pkg::idx_t     rd_idx,
    output ffba_pkg::entry_t   rd_data,
    output ffba_pkg::cnt_t     count
);

    ffba_pkg::entry_t mem_reg [ffba_pkg::MAX_BLOCKS];
    ffba_pkg::cnt_t   count_reg;
    ffba_pkg::cnt_t   count_next;

    for (genvar g = 0; g < ffba_pkg::MAX_BLOCKS; g++)
    begin : g_cell
        localparam ffba_pkg::entry_t RST_VAL = (g == 0) ? ffba_pkg::ENTRY_INIT : '0;
        ffba_pkg::entry_t below;
        ffba_pkg::entry_t above;
        ffba_pkg::entry_t cell_next;

        if (g == 0)
        begin : g_bot
            assign below = ctl.wdata;
        end
        else
        begin : g_mid
            assign below = mem_reg[g-1];
        end

        if (g == ffba_pkg::MAX_BLOCKS - 1)
        begin : g_top
            assign above = mem_reg[g];
        end
        else
        begin : g_low
            assign above = mem_reg[g+1];
        end

        always_comb
        begin
            cell_next = mem_reg[g];
            unique case (ctl.op)
                ffba_pkg::TBL_WRITE:
                begin
                    if (ctl.idx == ffba_pkg::idx_t'(g))
                        cell_next = ctl.wdata;
                end
                ffba_pkg::TBL_INSERT:
                begin
                    if (ctl.idx == ffba_pkg::idx_t'(g))
                        cell_next = ctl.wdata;
                    else if (ffba_pkg::idx_t'(g) > ctl.idx)
                        cell_next = below;
                end
                ffba_pkg::TBL_REMOVE:
                begin
                    if (ffba_pkg::idx_t'(g) >= ctl.idx)
                        cell_next = above;
                end
                default: cell_next = mem_reg[g];
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                mem_reg[g] <= RST_VAL;
            else
                mem_reg[g] <= cell_next;
        end
    end

    always_comb
    begin
        case (ctl.op)
            ffba_pkg::TBL_INSERT: count_next = count_reg + 1'b1;
            ffba_pkg::TBL_REMOVE: count_next = count_reg - 1'b1;
            default:              count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= ffba_pkg::cnt_t'(1);
        else
            count_reg <= count_next;
    end

    assign rd_data = mem_reg[rd_idx];
    assign count   = count_reg;

endmodule

>>> design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with split on allocate and coalescing on free.
// ----------------------------------------------------------------------------
//
//  channel   signals                    direction  handshake
//  --------  -------------------------  ---------  ------------------------------
//  command   start, busy, request       in         beat taken when start && !busy
//  result    done, result               out        one-cycle strobe, no backpressure
//  config    cfg_we, cfg_wdata          in         min_split written when cfg_we
//
//  Allocate adds the header and min_split, scans for the first fit and splits
//  off the tail if it is long enough and a slot is free; free scans for the
//  offset, merges a free successor, then a free predecessor. The table walk
//  takes one entry per cycle through the shared adder. done pulses the cycle
//  after the last step, as busy falls; a null free answers the cycle after.
//  Reset leaves one free block over the heap, min_split = 32; no result stalls.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
(
    input  logic                clk,
    input  logic                rst_n,
    // command
    input  logic                start,
    output logic                busy,
    input  ffba_pkg::cmd_t      request,
    // result
    output logic                done,
    output ffba_pkg::res_t      result,
    // configuration
    input  logic                cfg_we,
    input  ffba_pkg::split_t    cfg_wdata
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    ffba_pkg::state_t    state_reg,     state_next;
    ffba_pkg::split_t    min_split_reg;
    logic [ffba_pkg::CNT_W-1:0] idx_reg, idx_next;     // scan position
    ffba_pkg::req_size_t req_size_reg,  req_size_next;
    ffba_pkg::addr_t     req_addr_reg,  req_addr_next;
    ffba_pkg::alu_word_t need_reg,      need_next;     // req + header
    ffba_pkg::alu_word_t thr_reg,       thr_next;      // req + header + min_split
    ffba_pkg::alu_word_t tmp_reg,       tmp_next;      // partial merge sum / new size
    ffba_pkg::addr_t     cur_off_reg,   cur_off_next;
    ffba_pkg::blk_size_t cur_size_reg,  cur_size_next;
    ffba_pkg::addr_t     aux_reg,       aux_next;      // new offset / neighbor field
    logic                done_reg,      done_next;
    ffba_pkg::res_t      result_reg,    result_next;

    // ------------------------------------------------------------------
    // shared unit and table
    // ------------------------------------------------------------------
    ffba_pkg::alu_op_t   alu_op;
    ffba_pkg::alu_word_t alu_a;
    ffba_pkg::alu_word_t alu_b;
    ffba_pkg::alu_word_t alu_sum;
    logic                alu_ge;

    ffba_pkg::tbl_ctl_t  tbl_ctl;
    ffba_pkg::idx_t      rd_idx;
    ffba_pkg::entry_t    rd;
    ffba_pkg::cnt_t      count;

    logic                accept;
    logic                scan_end;
    logic                a_hit;
    logic                f_hit;
    logic                split_ok;
    logic                next_ok;
    logic                prev_ok;
    logic [ffba_pkg::CNT_W-1:0] idx_inc;

    ffba_alu u_alu
    (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .ge  (alu_ge)
    );

    ffba_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .rd_idx  (rd_idx),
        .rd_data (rd),
        .count   (count)
    );

    assign accept  = start && (state_reg == ffba_pkg::ST_IDLE);
    assign idx_inc = idx_reg + 1'b1;

    // read port follows the step: current, successor or predecessor entry
    always_comb
    begin
        case (state_reg)
            ffba_pkg::ST_F_NEXT: rd_idx = idx_inc[ffba_pkg::IDX_W-1:0];
            ffba_pkg::ST_F_PREV: rd_idx = idx_reg[ffba_pkg::IDX_W-1:0] - 1'b1;
            default:             rd_idx = idx_reg[ffba_pkg::IDX_W-1:0];
        endcase
    end

    // shared adder operand selection
    always_comb
    begin
        alu_op = ffba_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            ffba_pkg::ST_A_NEED:
            begin
                alu_a = ffba_pkg::alu_word_t'(req_size_reg);
                alu_b = ffba_pkg::HDR_WORD;
            end
            ffba_pkg::ST_A_THR:
            begin
                alu_a = need_reg;
                alu_b = ffba_pkg::alu_word_t'(min_split_reg);
            end
            ffba_pkg::ST_A_SCAN:
            begin
                alu_op = ffba_pkg::ALU_SUB;
                alu_a  = ffba_pkg::alu_word_t'(rd.size);
                alu_b  = ffba_pkg::alu_word_t'(req_size_reg);
            end
            ffba_pkg::ST_A_CHK:
            begin
                alu_op = ffba_pkg::ALU_SUB;
                alu_a  = ffba_pkg::alu_word_t'(cur_size_reg);
                alu_b  = thr_reg;
            end
            ffba_pkg::ST_A_NOFF:
            begin
                alu_a = ffba_pkg::alu_word_t'(cur_off_reg);
                alu_b = need_reg;
            end
            ffba_pkg::ST_A_NSIZE:
            begin
                alu_op = ffba_pkg::ALU_SUB;
                alu_a  = ffba_pkg::alu_word_t'(cur_size_reg);
                alu_b  = need_reg;
            end
            ffba_pkg::ST_A_GRANT:
            begin
                alu_a = ffba_pkg::alu_word_t'(cur_off_reg);
                alu_b = ffba_pkg::HDR_WORD;
            end
            ffba_pkg::ST_F_SCAN:
            begin
                alu_a = ffba_pkg::alu_word_t'(rd.offset);
                alu_b = ffba_pkg::HDR_WORD;
            end
            ffba_pkg::ST_F_NEXT:
            begin
                alu_a = ffba_pkg::alu_word_t'(cur_size_reg);
                alu_b = ffba_pkg::HDR_WORD;
            end
            ffba_pkg::ST_F_MRGN:
            begin
                alu_a = tmp_reg;
                alu_b = ffba_pkg::alu_word_t'(aux_reg);
            end
            ffba_pkg::ST_F_PREV:
            begin
                alu_a = ffba_pkg::alu_word_t'(rd.size);
                alu_b = ffba_pkg::HDR_WORD;
            end
            ffba_pkg::ST_F_MRGP:
            begin
                alu_a = tmp_reg;
                alu_b = ffba_pkg::alu_word_t'(cur_size_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // step conditions
    assign scan_end = (idx_reg == count);
    assign a_hit    = !scan_end && rd.is_free && alu_ge;
    assign f_hit    = !scan_end && !rd.is_free &&
                      (alu_sum == ffba_pkg::alu_word_t'(req_addr_reg));
    assign split_ok = (count != ffba_pkg::CNT_MAX) && alu_ge;
    assign next_ok  = (idx_inc < count) && rd.is_free;
    assign prev_ok  = (idx_reg != '0) && rd.is_free;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!request.mode)
                        state_next = ffba_pkg::ST_A_NEED;
                    else if (request.free_address != '0)
                        state_next = ffba_pkg::ST_F_SCAN;
                end
            end
            ffba_pkg::ST_A_NEED:  state_next = ffba_pkg::ST_A_THR;
            ffba_pkg::ST_A_THR:   state_next = ffba_pkg::ST_A_SCAN;
            ffba_pkg::ST_A_SCAN:
            begin
                if (scan_end)
                    state_next = ffba_pkg::ST_IDLE;
                else if (a_hit)
                    state_next = ffba_pkg::ST_A_CHK;
            end
            ffba_pkg::ST_A_CHK:
                state_next = split_ok ? ffba_pkg::ST_A_NOFF : ffba_pkg::ST_A_GRANT;
            ffba_pkg::ST_A_NOFF:  state_next = ffba_pkg::ST_A_NSIZE;
            ffba_pkg::ST_A_NSIZE: state_next = ffba_pkg::ST_A_INS;
            ffba_pkg::ST_A_INS:   state_next = ffba_pkg::ST_A_GRANT;
            ffba_pkg::ST_A_GRANT: state_next = ffba_pkg::ST_IDLE;
            ffba_pkg::ST_F_SCAN:
            begin
                if (scan_end)
                    state_next = ffba_pkg::ST_IDLE;
                else if (f_hit)
                    state_next = ffba_pkg::ST_F_NEXT;
            end
            ffba_pkg::ST_F_NEXT:
                state_next = next_ok ? ffba_pkg::ST_F_MRGN : ffba_pkg::ST_F_WRI;
            ffba_pkg::ST_F_MRGN:  state_next = ffba_pkg::ST_F_RMN;
            ffba_pkg::ST_F_RMN:   state_next = ffba_pkg::ST_F_WRI;
            ffba_pkg::ST_F_WRI:   state_next = ffba_pkg::ST_F_PREV;
            ffba_pkg::ST_F_PREV:
                state_next = prev_ok ? ffba_pkg::ST_F_MRGP : ffba_pkg::ST_IDLE;
            ffba_pkg::ST_F_MRGP:  state_next = ffba_pkg::ST_F_WRP;
            ffba_pkg::ST_F_WRP:   state_next = ffba_pkg::ST_F_RMI;
            ffba_pkg::ST_F_RMI:   state_next = ffba_pkg::ST_IDLE;
            default:              state_next = ffba_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs per step
    // ------------------------------------------------------------------
    always_comb
    begin
        idx_next      = idx_reg;
        req_size_next = req_size_reg;
        req_addr_next = req_addr_reg;
        need_next     = need_reg;
        thr_next      = thr_reg;
        tmp_next      = tmp_reg;
        cur_off_next  = cur_off_reg;
        cur_size_next = cur_size_reg;
        aux_next      = aux_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        tbl_ctl       = '{op: ffba_pkg::TBL_NOP, idx: '0, wdata: '0};

        case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_size_next = request.alloc_size;
                    req_addr_next = request.free_address;
                    idx_next      = '0;
                    // null free answers at once
                    if (request.mode && (request.free_address == '0))
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: ffba_pkg::STATUS_OK,
                                        granted_address: '0, granted_size: '0};
                    end
                end
            end
            ffba_pkg::ST_A_NEED: need_next = alu_sum;
            ffba_pkg::ST_A_THR:  thr_next  = alu_sum;
            ffba_pkg::ST_A_SCAN:
            begin
                if (scan_end)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ffba_pkg::STATUS_NOFIT,
                                    granted_address: '0, granted_size: '0};
                end
                else if (a_hit)
                begin
                    cur_off_next  = rd.offset;
                    cur_size_next = rd.size;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ffba_pkg::ST_A_NOFF: aux_next = alu_sum[ffba_pkg::ADDR_W-1:0];
            ffba_pkg::ST_A_NSIZE:
            begin
                tmp_next      = alu_sum;
                cur_size_next = req_size_reg[ffba_pkg::ADDR_W-1:0];
            end
            ffba_pkg::ST_A_INS:
            begin
                // remainder becomes a new free block right after this one
                tbl_ctl.op    = ffba_pkg::TBL_INSERT;
                tbl_ctl.idx   = idx_inc[ffba_pkg::IDX_W-1:0];
                tbl_ctl.wdata = '{offset: aux_reg,
                                  size: tmp_reg[ffba_pkg::ADDR_W-1:0],
                                  is_free: 1'b1};
            end
            ffba_pkg::ST_A_GRANT:
            begin
                tbl_ctl.op    = ffba_pkg::TBL_WRITE;
                tbl_ctl.idx   = idx_reg[ffba_pkg::IDX_W-1:0];
                tbl_ctl.wdata = '{offset: cur_off_reg, size: cur_size_reg, is_free: 1'b0};
                done_next     = 1'b1;
                result_next   = '{status: ffba_pkg::STATUS_OK,
                                  granted_address: alu_sum[ffba_pkg::ADDR_W-1:0],
                                  granted_size: cur_size_reg};
            end
            ffba_pkg::ST_F_SCAN:
            begin
                if (scan_end)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ffba_pkg::STATUS_BADADDR,
                                    granted_address: '0, granted_size: '0};
                end
                else if (f_hit)
                begin
                    cur_off_next  = rd.offset;
                    cur_size_next = rd.size;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ffba_pkg::ST_F_NEXT:
            begin
                if (next_ok)
                begin
                    tmp_next = alu_sum;
                    aux_next = rd.size;
                end
            end
            ffba_pkg::ST_F_MRGN: cur_size_next = alu_sum[ffba_pkg::ADDR_W-1:0];
            ffba_pkg::ST_F_RMN:
            begin
                tbl_ctl.op  = ffba_pkg::TBL_REMOVE;
                tbl_ctl.idx = idx_inc[ffba_pkg::IDX_W-1:0];
            end
            ffba_pkg::ST_F_WRI:
            begin
                tbl_ctl.op    = ffba_pkg::TBL_WRITE;
                tbl_ctl.idx   = idx_reg[ffba_pkg::IDX_W-1:0];
                tbl_ctl.wdata = '{offset: cur_off_reg, size: cur_size_reg, is_free: 1'b1};
            end
            ffba_pkg::ST_F_PREV:
            begin
                if (prev_ok)
                begin
                    tmp_next = alu_sum;
                    aux_next = rd.offset;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ffba_pkg::STATUS_OK,
                                    granted_address: '0, granted_size: '0};
                end
            end
            ffba_pkg::ST_F_MRGP: cur_size_next = alu_sum[ffba_pkg::ADDR_W-1:0];
            ffba_pkg::ST_F_WRP:
            begin
                // predecessor absorbs the freed block
                tbl_ctl.op    = ffba_pkg::TBL_WRITE;
                tbl_ctl.idx   = idx_reg[ffba_pkg::IDX_W-1:0] - 1'b1;
                tbl_ctl.wdata = '{offset: aux_reg, size: cur_size_reg, is_free: 1'b1};
            end
            ffba_pkg::ST_F_RMI:
            begin
                tbl_ctl.op  = ffba_pkg::TBL_REMOVE;
                tbl_ctl.idx = idx_reg[ffba_pkg::IDX_W-1:0];
                done_next   = 1'b1;
                result_next = '{status: ffba_pkg::STATUS_OK,
                                granted_address: '0, granted_size: '0};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffba_pkg::ST_IDLE;
            done_reg      <= 1'b0;
            min_split_reg <= ffba_pkg::MIN_SPLIT_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
                min_split_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        req_size_reg <= req_size_next;
        req_addr_reg <= req_addr_next;
        need_reg     <= need_next;
        thr_reg      <= thr_next;
        tmp_reg      <= tmp_next;
        cur_off_reg  <= cur_off_next;
        cur_size_reg <= cur_size_next;
        aux_reg      <= aux_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ffba_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit block allocator. Commands go in
// through the start/busy handshake from a queue of pending beats. A
// behavioral heap table is kept alongside the block and predicts every
// result beat. The run covers a directed opening, then random allocate and
// free traffic under several min_split settings, with random gaps.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic MODE_ALLOC     = 1'b0;
    localparam logic MODE_FREE      = 1'b1;
    localparam int   STALL_LIMIT    = 5000;  // cycles with no beat at all
    localparam int   DRAIN_CYCLES   = 64;    // a bit over one worst-case op
    localparam int   RAND_PER_PHASE = 190;

    logic             clk;
    logic             rst_n;
    logic             start   = 1'b0;
    logic             busy;
    ffba_pkg::cmd_t   request = '0;
    logic             done;
    ffba_pkg::res_t   result;
    logic             cfg_we;
    ffba_pkg::split_t cfg_wdata;

    first_fit_block_allocator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shadow heap: address-ordered block list, same layout rules as the
    // block (header ahead of each payload, first fit, split, coalesce).
    // ------------------------------------------------------------------
    typedef struct {
        int unsigned base;   // header offset
        int unsigned len;    // payload bytes
        bit          avail;  // free mark
    } heap_blk_t;

    heap_blk_t   heap_map[ffba_pkg::MAX_BLOCKS];
    int unsigned heap_cnt;
    int unsigned split_floor;   // mirror of min_split

    ffba_pkg::cmd_t  cmd_q[$];        // beats waiting for the driver
    ffba_pkg::res_t  expected_q[$];   // predicted results, oldest first
    ffba_pkg::addr_t live_q[$];       // granted payload offsets not yet scheduled for free

    logic took      = 1'b0;  // command beat taken at the last rising edge
    int   gap_left  = 0;
    int   issued    = 0;
    int   stall_cnt = 0;

    int n_mismatch = 0;
    int n_alloc_ok = 0;
    int n_split    = 0;
    int n_nofit    = 0;
    int n_free_ok  = 0;
    int n_merge    = 0;
    int n_badaddr  = 0;
    int n_null     = 0;
    int n_settings = 0;
    int peak_cnt   = 1;

    // pull entry idx out of the list, closing the hole
    function automatic void drop_blk(int unsigned idx);
        for (int unsigned k = idx; k + 1 < heap_cnt; k++)
            heap_map[k] = heap_map[k + 1];
        heap_cnt--;
    endfunction

    // apply one command to the shadow heap and return the result beat
    function automatic ffba_pkg::res_t heap_apply(ffba_pkg::cmd_t c);
        ffba_pkg::res_t r;
        int unsigned    req;
        int unsigned    addr;
        heap_blk_t      nb;
        r        = '0;
        r.status = ffba_pkg::STATUS_OK;
        req      = c.alloc_size;
        addr     = c.free_address;
        if (c.mode == MODE_ALLOC) begin
            r.status = ffba_pkg::STATUS_NOFIT;
            for (int unsigned i = 0; i < heap_cnt; i++) begin
                if (heap_map[i].avail && heap_map[i].len >= req) begin
                    // split only when the tail holds a header plus min_split
                    // and the table has room for one more entry
                    if (heap_cnt < ffba_pkg::MAX_BLOCKS &&
                        heap_map[i].len >= req + ffba_pkg::HEADER_BYTES + split_floor) begin
                        nb.base  = heap_map[i].base + ffba_pkg::HEADER_BYTES + req;
                        nb.len   = heap_map[i].len - req - ffba_pkg::HEADER_BYTES;
                        nb.avail = 1'b1;
                        heap_map[i].len = req;
                        for (int unsigned k = heap_cnt; k > i + 1; k--)
                            heap_map[k] = heap_map[k - 1];
                        heap_map[i + 1] = nb;
                        heap_cnt++;
                    end
                    heap_map[i].avail = 1'b0;
                    r.status          = ffba_pkg::STATUS_OK;
                    r.granted_address =
                        ffba_pkg::addr_t'(heap_map[i].base + ffba_pkg::HEADER_BYTES);
                    r.granted_size    = ffba_pkg::blk_size_t'(heap_map[i].len);
                    break;
                end
            end
        end else if (addr != 0) begin
            // anything but the payload offset of a live block is rejected,
            // double frees included
            r.status = ffba_pkg::STATUS_BADADDR;
            for (int unsigned i = 0; i < heap_cnt; i++) begin
                if (!heap_map[i].avail &&
                    heap_map[i].base + ffba_pkg::HEADER_BYTES == addr) begin
                    r.status          = ffba_pkg::STATUS_OK;
                    heap_map[i].avail = 1'b1;
                    // successor first, then predecessor
                    if (i + 1 < heap_cnt && heap_map[i + 1].avail) begin
                        heap_map[i].len += ffba_pkg::HEADER_BYTES + heap_map[i + 1].len;
                        drop_blk(i + 1);
                    end
                    if (i > 0 && heap_map[i - 1].avail) begin
                        heap_map[i - 1].len += ffba_pkg::HEADER_BYTES + heap_map[i].len;
                        drop_blk(i);
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    function automatic ffba_pkg::cmd_t mk_cmd(logic m, int unsigned sz, int unsigned ad);
        ffba_pkg::cmd_t c;
        c.mode         = m;
        c.alloc_size   = ffba_pkg::req_size_t'(sz);
        c.free_address = ffba_pkg::addr_t'(ad);
        return c;
    endfunction

    // Random beat. Mostly well-formed traffic: allocations of mostly small
    // sizes and frees of offsets that were really granted, so the table
    // fragments and coalesces. A slice is noise: null frees, random offsets
    // and raw 11-bit sizes (which mostly find no fit).
    function automatic ffba_pkg::cmd_t rand_cmd();
        ffba_pkg::cmd_t c;
        int unsigned    roll;
        int unsigned    pick;
        int unsigned    free_pct;
        c.mode         = MODE_ALLOC;
        c.alloc_size   = ffba_pkg::req_size_t'($urandom);
        c.free_address = ffba_pkg::addr_t'($urandom);
        roll           = $urandom_range(0, 99);
        free_pct       = (live_q.size() > 10) ? 70 : 45;
        if (roll < 2) begin
            c.mode         = MODE_FREE;
            c.free_address = '0;
        end else if (roll < 8) begin
            c.mode = logic'($urandom_range(0, 1));
        end else if (live_q.size() > 0 && roll < free_pct) begin
            c.mode         = MODE_FREE;
            pick           = $urandom_range(0, live_q.size() - 1);
            c.free_address = live_q[pick];
            // now and then keep it in the pool to provoke a double free
            if ($urandom_range(0, 9) != 0)
                live_q.delete(pick);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
                c.alloc_size = ffba_pkg::req_size_t'($urandom_range(0, 48));
            else if (roll < 95)
                c.alloc_size = ffba_pkg::req_size_t'($urandom_range(49, 400));
            else
                c.alloc_size = ffba_pkg::req_size_t'($urandom_range(401, 1024));
        end
        return c;
    endfunction

    // Gap after a beat: mostly none or short, a few long. Every 128 beats
    // the first 40 go back to back.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if ((issued % 128) < 40 || roll < 60)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. A beat stays on the port
    // until the rising edge with start && !busy takes it.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!start || took)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                request  <= cmd_q.pop_front();
                start    <= 1'b1;
                gap_left <= pick_gap();
                issued   <= issued + 1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, check a result beat against the oldest
    // prediction, then predict for a command beat taken at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_monitor
        ffba_pkg::res_t want;
        int unsigned    cnt_was;
        took <= rst_n && start && !busy;
        if (rst_n) begin
            if (done) begin
                if (expected_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: result beat with none pending: %0d %0d %0d",
                                 $time, result.status, result.granted_address,
                                 result.granted_size);
                end else begin
                    want = expected_q.pop_front();
                    if (result.status !== want.status ||
                        result.granted_address !== want.granted_address ||
                        result.granted_size !== want.granted_size) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"%0t: mismatch exp/got status %0d/%0d",
                                      " addr %0d/%0d size %0d/%0d"},
                                     $time, want.status, result.status,
                                     want.granted_address, result.granted_address,
                                     want.granted_size, result.granted_size);
                    end
                end
            end
            if (start && !busy) begin
                cnt_was = heap_cnt;
                want    = heap_apply(request);
                expected_q.push_back(want);
                if (heap_cnt > peak_cnt)
                    peak_cnt = heap_cnt;
                if (request.mode == MODE_ALLOC) begin
                    if (want.status == ffba_pkg::STATUS_OK) begin
                        n_alloc_ok++;
                        n_split += heap_cnt - cnt_was;
                        live_q.push_back(want.granted_address);
                    end else begin
                        n_nofit++;
                    end
                end else if (request.free_address == '0) begin
                    n_null++;
                end else if (want.status == ffba_pkg::STATUS_OK) begin
                    n_free_ok++;
                    n_merge += cnt_was - heap_cnt;
                end else begin
                    n_badaddr++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any beat or register write counts as progress.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results pending",
                     stall_cnt, expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------

    // wait until the driver queue is empty; resumes 1 ns after a rising
    // edge so the monitor's updates of that edge are visible
    task automatic wait_slot();
        do begin
            @(posedge clk);
            #1;
        end while (cmd_q.size() > 0);
    endtask

    task automatic push_cmd(ffba_pkg::cmd_t c);
        wait_slot();
        cmd_q.push_back(c);
    endtask

    // all beats sent, all results back, block not busy
    task automatic wait_idle();
        while (cmd_q.size() > 0 || start || busy || expected_q.size() > 0)
            @(negedge clk);
    endtask

    // min_split is written only with the block idle
    task automatic write_split(int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ffba_pkg::split_t'(val);
        @(negedge clk);
        cfg_we      <= 1'b0;
        split_floor = val & 32'h7FF;
        n_settings++;
    endtask

    // free every offset still in the pool so the next phase starts from
    // a fully coalesced heap
    task automatic release_all();
        wait_idle();
        while (live_q.size() > 0)
            push_cmd(mk_cmd(MODE_FREE, 0, live_q.pop_front()));
        wait_idle();
    endtask

    initial
    begin : stimulus
        int unsigned splits[5];
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;

        // shadow heap after reset: one free block over the whole heap
        heap_map[0] = '{base: 0, len: ffba_pkg::HEAP_BYTES - ffba_pkg::HEADER_BYTES,
                        avail: 1'b1};
        heap_cnt    = 1;
        split_floor = 32;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed opening at the reset min_split of 32
        push_cmd(mk_cmd(MODE_FREE, 0, 0));         // null free
        push_cmd(mk_cmd(MODE_FREE, 0, 32));        // nothing allocated yet
        push_cmd(mk_cmd(MODE_ALLOC, 0, 0));        // zero request, splits
        push_cmd(mk_cmd(MODE_ALLOC, 2047, 0));     // all-ones size, no fit
        push_cmd(mk_cmd(MODE_ALLOC, 1024, 0));     // beyond the heap
        push_cmd(mk_cmd(MODE_ALLOC, 100, 0));
        push_cmd(mk_cmd(MODE_ALLOC, 200, 0));
        push_cmd(mk_cmd(MODE_FREE, 0, 1023));      // all-ones offset, bad
        push_cmd(mk_cmd(MODE_FREE, 0, 64));        // neighbors both in use
        push_cmd(mk_cmd(MODE_FREE, 0, 64));        // double free
        push_cmd(mk_cmd(MODE_ALLOC, 50, 0));       // reuses the hole, no split
        push_cmd(mk_cmd(MODE_FREE, 0, 32));
        push_cmd(mk_cmd(MODE_FREE, 0, 64));        // merges with predecessor
        push_cmd(mk_cmd(MODE_FREE, 0, 196));       // merges both ways
        push_cmd(mk_cmd(MODE_ALLOC, 961, 0));      // tail too short, whole block
        push_cmd(mk_cmd(MODE_FREE, 0, 32));
        push_cmd(mk_cmd(MODE_ALLOC, 992, 0));      // exact fit of the full heap
        push_cmd(mk_cmd(MODE_FREE, 0, 32));
        push_cmd(mk_cmd(MODE_ALLOC, 896, 0));      // split, 64-byte tail
        push_cmd(mk_cmd(MODE_ALLOC, 32, 0));       // tail granted whole
        push_cmd(mk_cmd(MODE_FREE, 0, 32));
        push_cmd(mk_cmd(MODE_FREE, 0, 960));       // back to one free block
        wait_idle();
        live_q.delete();   // heap is fully free again; pool entries are stale

        // random phases, one per min_split setting, extremes included
        splits[0] = 0;
        splits[1] = 1024;
        splits[2] = 2047;
        splits[3] = $urandom_range(1, 200);
        splits[4] = 16;
        foreach (splits[p]) begin
            write_split(splits[p]);
            if (splits[p] == 0) begin
                // zero-size allocations until the table is full and the
                // last empty block is granted whole, then one no-fit
                repeat (ffba_pkg::MAX_BLOCKS + 1)
                    push_cmd(mk_cmd(MODE_ALLOC, 0, 0));
            end
            repeat (RAND_PER_PHASE) begin
                wait_slot();
                cmd_q.push_back(rand_cmd());
            end
            release_all();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d beats: %0d grants (%0d with split), %0d no-fit, %0d frees",
                 issued, n_alloc_ok, n_split, n_nofit, n_free_ok);
        $display("with %0d merges, %0d bad-offset and %0d null frees, table peak %0d",
                 n_merge, n_badaddr, n_null, peak_cnt);
        $display("over %0d min_split writes", n_settings);
        if (n_mismatch == 0 && expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
